FILE: rtl/atan2_pade_top_macros.svh
// ---------------------------------------------------------------------------
// atan2_pade_top_macros.svh
// Assertion shorthands shared by the atan2 Pade block.
// ---------------------------------------------------------------------------
`ifndef ATAN2_PADE_TOP_MACROS_SVH
`define ATAN2_PADE_TOP_MACROS_SVH

// expr holds at every clock edge outside reset
`define ATP_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons holds in the cycle after ante
`define ATP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/atp_pkg.sv
// ---------------------------------------------------------------------------
// atp_pkg
// Types, constants and helper functions for the atan2 Pade block.
// ---------------------------------------------------------------------------
package atp_pkg;

  localparam int DEF_COORD_WIDTH     = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 13;

  localparam int RATIO_FRAC = 18;
  localparam int U_W        = RATIO_FRAC + 1;
  localparam int U2_W       = 2 * U_W;
  localparam int A_W        = 41;
  localparam int SPLIT      = 21;
  localparam int REM_W      = 60;
  localparam int TINY_SCALE = 100000;
  localparam int TINY_W     = 17;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic [63:0]    PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [A_W-1:0] PADE_C15  = A_W'(15) << 36;

  typedef struct packed {
    logic x_zero;
    logic y_pos;
    logic y_neg;
    logic tiny;
    logic fold;
    logic same;
    logic x_neg;
  } atp_cls_t;

  function automatic logic [31:0] atp_pi_fixed(input int f);
    logic [63:0] t;
    t = (PI_Q60 + (64'd1 << (59 - f))) >> (60 - f);
    return t[31:0];
  endfunction

  function automatic logic [31:0] atp_hpi_fixed(input int f);
    logic [63:0] t;
    t = (PI_Q60 + (64'd1 << (60 - f))) >> (61 - f);
    return t[31:0];
  endfunction

endpackage

FILE: rtl/atp_queue.sv
// ---------------------------------------------------------------------------
// atp_queue
// Small first-in first-out queue, power-of-two depth.
// ---------------------------------------------------------------------------
`include "atan2_pade_top_macros.svh"

module atp_queue import atp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = MID_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ATP_ASSERT_HOLDS(a_count_range, count <= CW'(DEPTH), "queue count out of range")
  `ATP_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + 1'b1, "push lost")
  `ATP_ASSERT_NEXT(a_count_down, do_pop && !do_push, count == $past(count) - 1'b1, "pop lost")

endmodule

FILE: rtl/atp_front.sv
// ---------------------------------------------------------------------------
// atp_front
// Classifies a coordinate pair and picks dividend and divisor of the ratio.
// ---------------------------------------------------------------------------
module atp_front import atp_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  output logic        [COORD_WIDTH-1:0] dvd,
  output logic        [COORD_WIDTH-1:0] dvs,
  output atp_cls_t                      cls
);

  localparam int TW = COORD_WIDTH + TINY_W;

  logic [COORD_WIDTH-1:0] ay;
  logic [COORD_WIDTH-1:0] ax;
  logic [TW-1:0]          ay_scl;
  logic                   same;
  logic                   fold;

  assign ay     = coord_y[COORD_WIDTH-1] ? (~$unsigned(coord_y) + 1'b1) : $unsigned(coord_y);
  assign ax     = coord_x[COORD_WIDTH-1] ? (~$unsigned(coord_x) + 1'b1) : $unsigned(coord_x);
  assign ay_scl = TW'(ay) * TW'(TINY_SCALE);
  assign same   = (coord_y[COORD_WIDTH-1] == coord_x[COORD_WIDTH-1]);
  assign fold   = (same && (ay >= ax)) || (!same && (ay > ax));

  assign dvd = fold ? ax : ay;
  assign dvs = fold ? ay : ax;

  always_comb begin
    cls.x_zero = (coord_x == '0);
    cls.y_neg  = coord_y[COORD_WIDTH-1];
    cls.y_pos  = !coord_y[COORD_WIDTH-1] && (coord_y != '0);
    cls.tiny   = (ay_scl <= TW'(ax));
    cls.fold   = fold;
    cls.same   = same;
    cls.x_neg  = coord_x[COORD_WIDTH-1];
  end

endmodule

FILE: rtl/atp_div.sv
// ---------------------------------------------------------------------------
// atp_div
// Pipelined restoring divider: u = floor(dvd * 2^18 / dvs), dvd <= dvs.
// ---------------------------------------------------------------------------
module atp_div import atp_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [COORD_WIDTH-1:0] dvd,
  input  logic [COORD_WIDTH-1:0] dvs,
  input  atp_cls_t               in_cls,
  output logic                   out_valid,
  output logic [U_W-1:0]         u,
  output atp_cls_t               out_cls
);

  localparam int W = COORD_WIDTH;

  logic [W-1:0]   rem_q [U_W];
  logic [W-1:0]   dvs_q [U_W];
  logic [U_W-1:0] quo_q [U_W];
  atp_cls_t       cls_q [U_W];
  logic [U_W-1:0] vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= (dvd >= dvs) ? (dvd - dvs) : dvd;
      quo_q[0] <= U_W'(dvd >= dvs);
      dvs_q[0] <= dvs;
      cls_q[0] <= in_cls;
    end
  end

  for (genvar k = 1; k < U_W; k++) begin : g_step
    logic [W:0] sh;
    logic       ge;

    assign sh = {rem_q[k-1], 1'b0};
    assign ge = (sh >= {1'b0, dvs_q[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? W'(sh - {1'b0, dvs_q[k-1]}) : W'(sh);
        quo_q[k] <= {quo_q[k-1][U_W-2:0], ge};
        dvs_q[k] <= dvs_q[k-1];
        cls_q[k] <= cls_q[k-1];
      end
    end
  end

  assign out_valid = vld_q[U_W-1];
  assign u         = quo_q[U_W-1];
  assign out_cls   = cls_q[U_W-1];

endmodule

FILE: rtl/atp_pade.sv
// ---------------------------------------------------------------------------
// atp_pade
// Pade arctangent of the reduced ratio, quadrant fix-up and saturation.
// ---------------------------------------------------------------------------
module atp_pade import atp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [U_W-1:0]               u,
  input  atp_cls_t                     in_cls,
  output logic                         out_valid,
  output logic signed [ANGLE_FRAC_BITS+2:0] angle
);

  localparam int F       = ANGLE_FRAC_BITS;
  localparam int Q_W     = F + 1;
  localparam int ANGLE_W = F + 3;
  localparam int SUM_W   = F + 5;
  localparam int HI_W    = A_W - SPLIT;
  localparam logic [31:0] PI_F  = atp_pi_fixed(F);
  localparam logic [31:0] HPI_F = atp_hpi_fixed(F);

  // front of the rational: u^2, polynomials, numerator partial products
  logic [U_W-1:0]          u0, u1;
  logic [U2_W-1:0]         u2_0;
  logic [A_W-1:0]          a1, d1, d2;
  logic [U_W+HI_W-1:0]     pp_hi;
  logic [U_W+SPLIT-1:0]    pp_lo;
  logic [REM_W-1:0]        rem3, den3;
  atp_cls_t                cls0, cls1, cls2, cls3;
  logic [3:0]              vld_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= '0;
    end else if (en) begin
      vld_f <= {vld_f[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0    <= u;
      u2_0  <= u * u;
      cls0  <= in_cls;
      u1    <= u0;
      a1    <= PADE_C15 + A_W'({u2_0, 2'b0});
      d1    <= PADE_C15 + A_W'({u2_0, 3'b0}) + A_W'(u2_0);
      cls1  <= cls0;
      pp_hi <= u1 * a1[A_W-1:SPLIT];
      pp_lo <= u1 * a1[SPLIT-1:0];
      d2    <= d1;
      cls2  <= cls1;
      rem3  <= REM_W'({pp_hi, SPLIT'(0)}) + REM_W'(pp_lo);
      den3  <= REM_W'({d2, RATIO_FRAC'(0)});
      cls3  <= cls2;
    end
  end

  // quotient bits, one per stage
  logic [REM_W-1:0] rem_q [Q_W];
  logic [REM_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  atp_cls_t         cls_q [Q_W];
  logic [Q_W-1:0]   vld_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    atp_cls_t         cls_in;
    logic             vld_in;
    logic [REM_W:0]   sh;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = rem3;
      assign den_in = den3;
      assign quo_in = '0;
      assign cls_in = cls3;
      assign vld_in = vld_f[3];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign cls_in = cls_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign sh = {rem_in, 1'b0};
    assign ge = (sh >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? REM_W'(sh - {1'b0, den_in}) : REM_W'(sh);
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[Q_W-2:0], ge};
        cls_q[k] <= cls_in;
      end
    end
  end

  // rounding, quadrant fix-up, clamp
  logic [Q_W:0]              q_p1;
  logic signed [SUM_W-1:0]   pv, hpv, piv, part, tot, sat;
  atp_cls_t                  c;
  logic                      vld_o;

  assign c    = cls_q[Q_W-1];
  assign q_p1 = {1'b0, quo_q[Q_W-1]} + 1'b1;
  assign pv   = $signed(SUM_W'(q_p1[Q_W:1]));
  assign hpv  = $signed(SUM_W'(HPI_F));
  assign piv  = $signed(SUM_W'(PI_F));

  always_comb begin
    if (c.tiny) begin
      part = '0;
    end else if (c.fold) begin
      part = c.same ? (hpv - pv) : (pv - hpv);
    end else begin
      part = c.same ? pv : -pv;
    end
    if (c.x_zero) begin
      tot = c.y_pos ? hpv : (c.y_neg ? -hpv : '0);
    end else if (c.x_neg) begin
      tot = c.y_neg ? (part - piv) : (part + piv);
    end else begin
      tot = part;
    end
    if (tot > piv) begin
      sat = piv;
    end else if (tot < -piv) begin
      sat = -piv;
    end else begin
      sat = tot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_q[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= sat[ANGLE_W-1:0];
    end
  end

  assign out_valid = vld_o;

endmodule

FILE: rtl/atan2_pade_top.sv
// ---------------------------------------------------------------------------
// atan2_pade_top
// Four-quadrant arctangent of (coord_x, coord_y), Pade approximation.
// Takes one coordinate pair per clock and delivers one angle per clock,
// radians with ANGLE_FRAC_BITS fractional bits, saturated to +-pi. From a
// push, an item goes through the ratio divider (one quotient bit per
// stage, the first one taking the item out of the input queue), the Pade
// polynomials, the Pade quotient, rounding and quadrant correction, and
// into the result queue. While the result queue is full the whole compute
// pipeline holds; the input queue keeps taking items until it fills.
// ---------------------------------------------------------------------------
module atan2_pade_top import atp_pkg::*; #(
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [COORD_WIDTH-1:0]     coord_y,
  input  logic signed [COORD_WIDTH-1:0]     coord_x,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [ANGLE_FRAC_BITS+2:0] angle
);

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
  localparam int CLS_W   = $bits(atp_cls_t);
  localparam int MID_W   = CLS_W + 2 * COORD_WIDTH;

  logic [COORD_WIDTH-1:0] f_dvd, f_dvs, m_dvd, m_dvs;
  atp_cls_t               f_cls, m_cls, d_cls;
  logic [MID_W-1:0]       m_rdata;
  logic                   m_empty;
  logic                   en;
  logic                   out_full;
  logic                   d_valid;
  logic [U_W-1:0]         d_u;
  logic                   p_valid;
  logic signed [ANGLE_W-1:0] p_angle;
  logic [ANGLE_W-1:0]     o_rdata;

  atp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .coord_y (coord_y),
    .coord_x (coord_x),
    .dvd     (f_dvd),
    .dvs     (f_dvs),
    .cls     (f_cls)
  );

  atp_queue #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata ({f_cls, f_dvd, f_dvs}),
    .pop   (en),
    .empty (m_empty),
    .rdata (m_rdata)
  );

  assign {m_cls, m_dvd, m_dvs} = m_rdata;
  assign en = !out_full;

  atp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (!m_empty),
    .dvd       (m_dvd),
    .dvs       (m_dvs),
    .in_cls    (m_cls),
    .out_valid (d_valid),
    .u         (d_u),
    .out_cls   (d_cls)
  );

  atp_pade #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pade (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .u         (d_u),
    .in_cls    (d_cls),
    .out_valid (p_valid),
    .angle     (p_angle)
  );

  atp_queue #(.WIDTH(ANGLE_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (en && p_valid),
    .full  (out_full),
    .wdata ($unsigned(p_angle)),
    .pop   (pop),
    .empty (empty),
    .rdata (o_rdata)
  );

  assign angle = $signed(o_rdata);

endmodule

FILE: verif/atan2_pade_top_tb.sv
// ---------------------------------------------------------------------------
// atan2_pade_top_tb
// Self-checking testbench for the atan2 Pade block.
// Drives coordinate pairs through the input queue with random bursts and
// gaps, drains angles with a random stall pattern, and compares each angle
// against a bit-exact fixed-point predictor, or against the known angle
// that a directed row gives. A directed table covers axes, extremes, the
// tiny-ratio cutoff, folding and saturation, then random pairs follow.
// ---------------------------------------------------------------------------
module atan2_pade_top_tb;
  import atp_pkg::*;

  localparam int CW = DEF_COORD_WIDTH;
  localparam int FB = DEF_ANGLE_FRAC_BITS;
  localparam int AW = FB + 3;
  localparam int LATENCY = FB + 26;
  localparam int N_RANDOM = 1700;
  localparam int WATCHDOG = 20000;
  localparam logic signed [AW-1:0] PI_F  = 16'sd25736;
  localparam logic signed [AW-1:0] HPI_F = 16'sd12868;

  typedef struct {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
    logic                 known;
    logic signed [AW-1:0] ang;
  } pair_row_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic signed [CW-1:0] coord_y;
  logic signed [CW-1:0] coord_x;
  logic                 empty;
  logic                 pop;
  logic signed [AW-1:0] angle;

  logic signed [AW-1:0] angle_q[$];
  pair_row_t            rows[$];
  int                   errors;
  int                   idle_cycles;
  bit                   mid_drained;

  atan2_pade_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .coord_y(coord_y),
    .coord_x(coord_x), .empty(empty), .pop(pop), .angle(angle)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint pade_mag(longint unsigned u);
    longint unsigned u2, num, den, q, rem;
    u2 = u * u;
    num = u * ((64'd15 << 36) + 64'd4 * u2);
    den = ((64'd15 << 36) + 64'd9 * u2) << RATIO_FRAC;
    q = num / den;
    rem = num - q * den;
    for (int i = 0; i < FB + 1; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 64'd1;
      end
    end
    return longint'((q + 64'd1) >> 1);
  endfunction

  function automatic logic signed [AW-1:0] predict_angle(logic signed [CW-1:0] y,
                                                         logic signed [CW-1:0] x);
    longint yy, xx, part, a;
    longint unsigned ay, ax;
    bit same;
    yy = y;
    xx = x;
    ay = yy < 0 ? -yy : yy;
    ax = xx < 0 ? -xx : xx;
    if (xx == 0) begin
      part = yy > 0 ? HPI_F : (yy < 0 ? -HPI_F : 0);
    end else begin
      same = (yy >= 0) == (xx >= 0);
      if (ay * 100000 <= ax) begin
        part = 0;
      end else if (same && ay >= ax) begin
        part = HPI_F - pade_mag((ax << RATIO_FRAC) / ay);
      end else if (!same && ay > ax) begin
        part = -HPI_F + pade_mag((ax << RATIO_FRAC) / ay);
      end else begin
        a = pade_mag((ay << RATIO_FRAC) / ax);
        part = same ? a : -a;
      end
      if (xx < 0) part = part + ((yy < 0) ? -PI_F : PI_F);
    end
    if (part > PI_F) part = PI_F;
    if (part < -PI_F) part = -PI_F;
    return AW'(part);
  endfunction

  task automatic add_row(int y, int x, bit known = 0, int ang = 0);
    pair_row_t r;
    r.y = CW'(y);
    r.x = CW'(x);
    r.known = known;
    r.ang = AW'(ang);
    rows.push_back(r);
  endtask

  task automatic send_pair(pair_row_t r);
    coord_y <= r.y;
    coord_x <= r.x;
    push <= 1'b1;
    do @(posedge clk); while (full);
    angle_q.push_back(r.known ? r.ang : predict_angle(r.y, r.x));
    @(negedge clk);
  endtask

  task automatic pause_send();
    push <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // Receiver: stall pattern steps through four patterns as time advances
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      case (($time / 768) % 4)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) begin
        if (angle_q.size() == 0) begin
          $display("%0t: angle %0d with no transfer outstanding", $time, angle);
          errors++;
        end else begin
          if (angle !== angle_q[0]) begin
            $display("%0t: angle mismatch expected %0d actual %0d", $time,
                     angle_q[0], angle);
            errors++;
          end
          void'(angle_q.pop_front());
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    pair_row_t r;
    int burst;
    errors = 0;
    idle_cycles = 0;
    mid_drained = 0;
    rst = 1'b1;
    push = 1'b0;
    coord_y = '0;
    coord_x = '0;
    add_row(0, 0, 1, 0);
    add_row(1, 0, 1, 12868);
    add_row(-1, 0, 1, -12868);
    add_row(32767, 0, 1, 12868);
    add_row(-32768, 0, 1, -12868);
    add_row(0, 5, 1, 0);
    add_row(0, -5, 1, 25736);
    add_row(0, -32768, 1, 25736);
    add_row(1, 32767, 1, 0);
    add_row(-1, -32768, 1, -25736);
    add_row(1, -32768, 1, 25736);
    add_row(1, 100000 / 1000);
    add_row(32767, 32767);
    add_row(-32768, -32768);
    add_row(32767, -32768);
    add_row(-32768, 32767);
    add_row(32767, 1);
    add_row(-32768, 1);
    add_row(32767, -1);
    add_row(-32768, -1);
    add_row(100, 101);
    add_row(-101, 100);
    add_row(1, 2);
    add_row(-3, -7);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (rows[i]) send_pair(rows[i]);
    pause_send();
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM && (mid_drained || n != N_RANDOM / 2);
           k++, n++) begin
        case ($urandom_range(0, 5))
          0: begin
            r.y = CW'($urandom_range(0, 15)) - 8;
            r.x = CW'($urandom);
          end
          1: begin
            r.y = CW'($urandom);
            r.x = CW'($urandom_range(0, 15)) - 8;
          end
          2: begin
            r.y = CW'($urandom);
            r.x = ($urandom_range(0, 1)) ? r.y : -r.y;
          end
          default: begin
            r.y = CW'($urandom);
            r.x = CW'($urandom);
          end
        endcase
        r.known = 0;
        send_pair(r);
      end
      if (!mid_drained && n == N_RANDOM / 2) begin
        push <= 1'b0;
        while (angle_q.size() != 0) @(negedge clk);
        mid_drained = 1;
      end else begin
        pause_send();
      end
    end
    push <= 1'b0;
    while (angle_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && angle_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
